>>> src/bce_pkg.sv
`default_nettype none

package bce_pkg;

   localparam int SECTIONS   = 4;
   localparam int SEC_IDX_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int SEC_CNT_W  = $clog2(SECTIONS + 1);

   localparam int COEF_SLOTS = 5;
   localparam int HIST_TAPS  = 4;
   localparam int COEF_DEPTH = SECTIONS * COEF_SLOTS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int HIST_DEPTH = SECTIONS * HIST_TAPS;
   localparam int HIST_AW    = SEC_IDX_W + 2;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int COEF_W     = 32;
   localparam int HIST_W     = 40;
   localparam int SPLIT_W    = 20;               // low part of a Q23.16 operand
   localparam int MUL_B_W    = HIST_W - SPLIT_W + 1;
   localparam int MUL_W      = COEF_W + MUL_B_W;
   localparam int PROD_SHIFT = 28 - SPLIT_W;     // remaining Q3.28 scale
   localparam int ACC_W      = 47;
   localparam int OUT_SHIFT  = 16;               // Q23.16 to integer

   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 16;

   localparam logic [CSR_AW-1:0] CSR_ENABLE        = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_SECTION_COUNT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_PRE_GAIN      = 2'd2;

   localparam logic MODE_AUDIO = 1'b0;
   localparam logic MODE_COEF  = 1'b1;

   localparam logic [2:0] SLOT_B0 = 3'd0;
   localparam logic [2:0] SLOT_B1 = 3'd1;
   localparam logic [2:0] SLOT_B2 = 3'd2;
   localparam logic [2:0] SLOT_A1 = 3'd3;
   localparam logic [2:0] SLOT_A2 = 3'd4;

   localparam logic [GAIN_W-1:0] PRE_GAIN_RESET = 16'd16384;

   typedef struct packed {
      logic mul_en;    // run the multiplier this cycle
      logic lo_half;   // operand is the low part; accumulate next cycle
      logic sub;       // feedback term, subtract
      logic clear;     // zero the accumulator
   } mac_ctl_type;

endpackage

`default_nettype wire

>>> src/bce_mac.sv
`default_nettype none

module bce_mac (
   input  wire                                       clock,
   input  wire                                       reset,
   input  bce_pkg::mac_ctl_type                      ctl,
   input  wire logic signed [bce_pkg::COEF_W-1:0]    mul_a,
   input  wire logic signed [bce_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [bce_pkg::MUL_W-1:0]          mul_q,
   output logic signed [bce_pkg::HIST_W-1:0]         sec_y
);
   import bce_pkg::*;

   logic signed [MUL_W-1:0] mul_ff;
   logic signed [MUL_W-1:0] hi_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic                    pend_ff;
   logic                    sub_ff;
   logic signed [MUL_W-1:0] lo_sh;
   logic signed [MUL_W:0]   prod_sum;
   logic signed [ACC_W-1:0] term;

   // floor(c*v / 2^28) = floor((c*vh + floor(c*vl / 2^20)) / 2^8)
   always_comb begin
      lo_sh    = mul_ff >>> SPLIT_W;
      prod_sum = (MUL_W+1)'(hi_ff) + (MUL_W+1)'(lo_sh);
      term     = ACC_W'(prod_sum >>> PROD_SHIFT);
      acc_in   = sub_ff ? (acc_ff - term) : (acc_ff + term);
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         mul_ff <= mul_a * mul_b;
      end
      if (ctl.mul_en && ctl.lo_half) begin
         hi_ff <= mul_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         sub_ff  <= 1'b0;
         acc_ff  <= '0;
      end else begin
         pend_ff <= ctl.mul_en && ctl.lo_half;
         sub_ff  <= ctl.sub;
         if (ctl.clear) begin
            acc_ff <= '0;
         end else if (pend_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_comb begin
      if (acc_ff[ACC_W-1:HIST_W-1] == '0 || acc_ff[ACC_W-1:HIST_W-1] == '1) begin
         sec_y = acc_ff[HIST_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sec_y = {1'b1, {(HIST_W-1){1'b0}}};
      end else begin
         sec_y = {1'b0, {(HIST_W-1){1'b1}}};
      end
   end

   assign mul_q = mul_ff;

endmodule

`default_nettype wire

>>> src/biquad_cascade_equalizer_core.sv
`default_nettype none
// Bypassed frame: the sample goes straight to ST_DONE and the registered response.
// Filtered frame: ST_GAIN, ST_GAIN_WB, ST_MAC/ST_DRAIN/ST_WB per section in use,
// ST_FINAL, ST_DONE; one shared 32x21 multiplier takes two passes per coefficient
// product. Requests stall outside ST_IDLE. Coefficient write: no response.
// Synchronous reset clears control state and all section history and sets the config
// registers to defaults; coefficients are undefined until written.

module biquad_cascade_equalizer_core (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_stall,
   input  wire                                        req_mode,
   input  wire logic signed [bce_pkg::SAMPLE_W-1:0]   req_left_sample,
   input  wire logic signed [bce_pkg::SAMPLE_W-1:0]   req_right_sample,
   input  wire                                        req_frame_end,
   input  wire logic [1:0]                            req_coef_section,
   input  wire logic [2:0]                            req_coef_slot,
   input  wire logic signed [bce_pkg::COEF_W-1:0]     req_coef_value,
   output logic                                       rsp_valid,
   input  wire                                        rsp_stall,
   output logic signed [bce_pkg::SAMPLE_W-1:0]        rsp_left_out,
   output logic signed [bce_pkg::SAMPLE_W-1:0]        rsp_right_out,
   output logic                                       rsp_frame_end_out,
   input  wire                                        csr_write_en,
   input  wire logic [bce_pkg::CSR_AW-1:0]            csr_index,
   input  wire logic [bce_pkg::CSR_DW-1:0]            csr_write_data
);
   import bce_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN,
      ST_GAIN_WB,
      ST_MAC,
      ST_DRAIN,
      ST_WB,
      ST_FINAL,
      ST_DONE
   } state_type;

   // configuration
   logic                enable_ff;
   logic [2:0]          section_count_ff;
   logic [GAIN_W-1:0]   pre_gain_ff;

   // sequencer
   state_type               state_ff, state_in;
   logic [SEC_CNT_W-1:0]    sec_ff, sec_in;
   logic [SEC_CNT_W-1:0]    n_ff, n_in;
   logic [2:0]              term_ff, term_in;
   logic                    half_ff, half_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [HIST_W-1:0]   x_ff, x_in;
   logic signed [SAMPLE_W-1:0] res_left_ff, res_left_in;
   logic signed [SAMPLE_W-1:0] res_right_ff, res_right_in;
   logic                    fend_ff, fend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;
   logic                    rsp_fend_ff, rsp_fend_in;

   // stores
   logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
   logic signed [HIST_W-1:0] hist_ff [HIST_DEPTH];

   logic                    req_accept;
   logic                    coef_wr;
   logic [COEF_AW-1:0]      coef_wr_addr;
   logic [SEC_IDX_W-1:0]    coef_wr_sec;
   logic [SEC_IDX_W-1:0]    sec_idx;
   logic [COEF_AW-1:0]      coef_rd_addr;
   logic [HIST_AW-1:0]      hist_rd_addr;
   logic signed [HIST_W-1:0] operand;
   logic                    hist_shift;

   mac_ctl_type                ctl;
   logic signed [COEF_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_W-1:0]    mul_q;
   logic signed [HIST_W-1:0]   sec_y;

   logic signed [HIST_W-1:0]          x_adj;
   logic signed [HIST_W-OUT_SHIFT-1:0] q_int;
   logic signed [SAMPLE_W-1:0]        q_sat;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign coef_wr = req_accept && (req_mode == MODE_COEF)
                    && (int'(req_coef_section) < SECTIONS)
                    && (req_coef_slot <= SLOT_A2);
   assign coef_wr_addr = COEF_AW'(int'(req_coef_section) * COEF_SLOTS + int'(req_coef_slot));
   assign coef_wr_sec  = SEC_IDX_W'(req_coef_section);

   assign sec_idx      = SEC_IDX_W'(sec_ff);
   assign coef_rd_addr = COEF_AW'(int'(sec_idx) * COEF_SLOTS + int'(term_ff));
   assign hist_rd_addr = {sec_idx, 2'(term_ff - 3'd1)};
   assign operand      = (term_ff == SLOT_B0) ? x_ff : hist_ff[hist_rd_addr];

   // truncate toward zero, then clamp to 16 bits
   always_comb begin
      x_adj = x_ff + (x_ff[HIST_W-1] ? HIST_W'((1 << OUT_SHIFT) - 1) : '0);
      q_int = x_adj[HIST_W-1:OUT_SHIFT];
      if (q_int[HIST_W-OUT_SHIFT-1:SAMPLE_W-1] == '0
          || q_int[HIST_W-OUT_SHIFT-1:SAMPLE_W-1] == '1) begin
         q_sat = q_int[SAMPLE_W-1:0];
      end else if (q_int[HIST_W-OUT_SHIFT-1]) begin
         q_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         q_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   // multiplier operands
   always_comb begin
      if (state_ff == ST_GAIN) begin
         mul_a = COEF_W'(sample_ff);
         mul_b = signed'(MUL_B_W'({1'b0, pre_gain_ff}));
      end else begin
         mul_a = coef_mem[coef_rd_addr];
         mul_b = half_ff ? signed'(MUL_B_W'({1'b0, operand[SPLIT_W-1:0]}))
                         : MUL_B_W'(signed'(operand[HIST_W-1:SPLIT_W]));
      end
   end

   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      n_in         = n_ff;
      term_in      = term_ff;
      half_in      = half_ff;
      sample_in    = sample_ff;
      x_in         = x_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      fend_in      = fend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_fend_in  = rsp_fend_ff;
      ctl          = '0;
      hist_shift   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_mode == MODE_AUDIO) begin
               sample_in    = req_left_sample;
               res_left_in  = req_left_sample;
               res_right_in = req_right_sample;
               fend_in      = req_frame_end;
               n_in = (int'(section_count_ff) > SECTIONS) ? SEC_CNT_W'(SECTIONS)
                                                          : SEC_CNT_W'(section_count_ff);
               state_in = enable_ff ? ST_GAIN : ST_DONE;
            end
         end
         ST_GAIN: begin
            ctl.mul_en = 1'b1;
            state_in   = ST_GAIN_WB;
         end
         ST_GAIN_WB: begin
            // sample * gain(Q2.14) * 4 gives Q23.16
            x_in      = {mul_q[HIST_W-3:0], 2'b00};
            ctl.clear = 1'b1;
            sec_in    = '0;
            term_in   = SLOT_B0;
            half_in   = 1'b0;
            state_in  = (n_ff == '0) ? ST_FINAL : ST_MAC;
         end
         ST_MAC: begin
            ctl.mul_en  = 1'b1;
            ctl.lo_half = half_ff;
            ctl.sub     = (term_ff >= SLOT_A1);
            half_in     = !half_ff;
            if (half_ff) begin
               if (term_ff == SLOT_A2) begin
                  state_in = ST_DRAIN;
               end else begin
                  term_in = term_ff + 3'd1;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            hist_shift = 1'b1;
            ctl.clear  = 1'b1;
            x_in       = sec_y;
            sec_in     = sec_ff + 1'b1;
            term_in    = SLOT_B0;
            half_in    = 1'b0;
            state_in   = (sec_ff + 1'b1 >= n_ff) ? ST_FINAL : ST_MAC;
         end
         ST_FINAL: begin
            res_left_in  = q_sat;
            res_right_in = q_sat;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_left_ff;
               rsp_right_in = res_right_ff;
               rsp_fend_in  = fend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sec_ff       <= '0;
         n_ff         <= '0;
         term_ff      <= SLOT_B0;
         half_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sec_ff       <= sec_in;
         n_ff         <= n_in;
         term_ff      <= term_in;
         half_ff      <= half_in;
      end
      sample_ff    <= sample_in;
      x_ff         <= x_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      fend_ff      <= fend_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_fend_ff  <= rsp_fend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         section_count_ff <= '0;
         pre_gain_ff      <= PRE_GAIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLE:        enable_ff        <= csr_write_data[0];
            CSR_SECTION_COUNT: section_count_ff <= csr_write_data[2:0];
            CSR_PRE_GAIN:      pre_gain_ff      <= csr_write_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (coef_wr) begin
         coef_mem[coef_wr_addr] <= req_coef_value;
      end
   end

   // per section: x1, x2, y1, y2
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (coef_wr) begin
         for (int k = 0; k < HIST_TAPS; k++) begin
            hist_ff[{coef_wr_sec, 2'(k)}] <= '0;
         end
      end else if (hist_shift) begin
         hist_ff[{sec_idx, 2'd1}] <= hist_ff[{sec_idx, 2'd0}];
         hist_ff[{sec_idx, 2'd0}] <= x_ff;
         hist_ff[{sec_idx, 2'd3}] <= hist_ff[{sec_idx, 2'd2}];
         hist_ff[{sec_idx, 2'd2}] <= sec_y;
      end
   end

   bce_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q),
      .sec_y (sec_y)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_out      = rsp_left_ff;
   assign rsp_right_out     = rsp_right_ff;
   assign rsp_frame_end_out = rsp_fend_ff;

endmodule

`default_nettype wire
